// ===== rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types and constants of the SHA-256 stream hasher: initial hash
// words, round constants, working-variable struct and block positions.
// ----------------------------------------------------------------------------
package shs_pkg;

   // Eight 32-bit words, index 0 is the most significant word
   typedef logic [0:7][31:0] shs_hash_type;

   // Working variables a..h of one compression, a in the top bits
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
      logic [31:0] f;
      logic [31:0] g;
      logic [31:0] h;
   } shs_work_type;

   // Last byte and first length byte within a 64-byte block
   localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
   localparam logic [5:0] LEN_FIELD_POS  = 6'd56;
   localparam logic [5:0] LAST_ROUND     = 6'd63;
   localparam logic [2:0] LAST_WORD_NUM  = 3'd7;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam shs_hash_type INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

// ===== rtl/shs_stream_if.sv =====
// ----------------------------------------------------------------------------
// shs_req_if / shs_rsp_if
// Valid/ready channels of the hasher: message bytes in, digest words out.
// ----------------------------------------------------------------------------

// Message channel: one byte and/or an end-of-message mark per transaction
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

// Digest channel: one 32-bit digest word per transaction
interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source (output valid, output digest_word, output word_number,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_number,
                   input last_word, output ready);
endinterface

// ===== rtl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256: collects message bytes into 64-byte blocks, runs the
// compression one round per cycle, pads on end of message and returns the
// eight digest words.
//
//   channel | dir | payload                                   | accepted when
//   req     | in  | data_byte, byte_present, end_of_message   | valid & ready
//   rsp     | out | digest_word, word_number, last_word       | valid & ready
//
// The 64th byte of a block starts the compression: the 64 rounds run
// through the shared round unit, then the chaining update adds the working
// variables into the hash words.
// End of message shifts in the padding one byte per cycle (64 - fill bytes,
// plus 64 more when the length spills into a second block), each padding
// block followed by a compression, then holds the eight words on rsp.
// req.ready is low while a block is compressed and, once an end of
// message is taken, until the eighth digest word is taken. Reset is
// synchronous and restores the initial hash words and a zero length.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic              clock,
   input  logic              reset,
   shs_req_if.sink           req,
   shs_rsp_if.source         rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_OUT
   } state_type;

   state_type              state_ff;
   shs_pkg::shs_hash_type  cv_ff;
   shs_pkg::shs_work_type  work_ff;
   shs_pkg::shs_work_type  work_next;
   shs_pkg::shs_hash_type  work_vec;
   logic [511:0]           blk_ff;      // byte buffer, doubles as schedule window
   logic [60:0]            len_ff;
   logic [63:0]            bits_ff;     // bit count, shifted out MSB first
   logic [5:0]             rnd_ff;
   logic [5:0]             pos_ff;
   logic [2:0]             word_ff;
   logic                   end_pend_ff;
   logic                   pad_act_ff;
   logic                   pad_first_ff;
   logic                   final_ff;

   logic                   req_fire;
   logic                   rsp_fire;
   logic [60:0]            len_inc;
   logic [60:0]            len_now;
   logic                   in_len_field;
   logic [7:0]             pad_byte;
   logic [31:0]            w_new;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign len_inc  = len_ff + 61'd1;
   assign len_now  = req.byte_present ? len_inc : len_ff;
   assign work_vec = work_ff;

   // padding byte stream: marker, zeros, then the bit count in the final block
   assign in_len_field = final_ff && (pos_ff >= shs_pkg::LEN_FIELD_POS);
   always_comb begin
      if (pad_first_ff) begin
         pad_byte = shs_pkg::PAD_MARKER;
      end else if (in_len_field) begin
         pad_byte = bits_ff[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // shared round unit
   shs_round u_round (
      .work      (work_ff),
      .window    (blk_ff),
      .round_k   (shs_pkg::ROUND_K[rnd_ff]),
      .work_next (work_next),
      .w_new     (w_new)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cv_ff        <= shs_pkg::INIT_HASH;
         len_ff       <= '0;
         rnd_ff       <= '0;
         word_ff      <= '0;
         end_pend_ff  <= 1'b0;
         pad_act_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req.byte_present) begin
                     blk_ff <= {blk_ff[503:0], req.data_byte};
                     len_ff <= len_inc;
                  end
                  end_pend_ff  <= req.end_of_message;
                  pad_first_ff <= 1'b1;
                  pad_act_ff   <= 1'b0;
                  pos_ff       <= len_now[5:0];
                  bits_ff      <= {len_now, 3'b000};
                  final_ff     <= (len_now[5:0] < shs_pkg::LEN_FIELD_POS);
                  if (req.byte_present && (len_ff[5:0] == shs_pkg::BLOCK_LAST_POS)) begin
                     state_ff <= ST_ROUND;
                     rnd_ff   <= '0;
                     work_ff  <= shs_pkg::shs_work_type'(cv_ff);
                  end else if (req.end_of_message) begin
                     state_ff   <= ST_PAD;
                     pad_act_ff <= 1'b1;
                  end
               end
            end

            ST_ROUND: begin
               work_ff <= work_next;
               blk_ff  <= {blk_ff[479:0], w_new};
               rnd_ff  <= rnd_ff + 6'd1;
               if (rnd_ff == shs_pkg::LAST_ROUND) begin
                  state_ff <= ST_UPDATE;
               end
            end

            ST_UPDATE: begin
               for (int i = 0; i < 8; i++) begin
                  cv_ff[i] <= cv_ff[i] + work_vec[i];
               end
               if (!end_pend_ff) begin
                  state_ff <= ST_IDLE;
               end else if (pad_act_ff && final_ff) begin
                  state_ff <= ST_OUT;
                  word_ff  <= '0;
               end else if (pad_act_ff) begin
                  // first padding block was full, length goes in a second one
                  final_ff <= 1'b1;
                  state_ff <= ST_PAD;
               end else begin
                  // data block done, end mark still pending
                  pad_act_ff <= 1'b1;
                  state_ff   <= ST_PAD;
               end
            end

            ST_PAD: begin
               blk_ff       <= {blk_ff[503:0], pad_byte};
               pad_first_ff <= 1'b0;
               pos_ff       <= pos_ff + 6'd1;
               if (in_len_field) begin
                  bits_ff <= {bits_ff[55:0], 8'h00};
               end
               if (pos_ff == shs_pkg::BLOCK_LAST_POS) begin
                  state_ff <= ST_ROUND;
                  rnd_ff   <= '0;
                  work_ff  <= shs_pkg::shs_work_type'(cv_ff);
               end
            end

            ST_OUT: begin
               if (rsp_fire) begin
                  word_ff <= word_ff + 3'd1;
                  if (word_ff == shs_pkg::LAST_WORD_NUM) begin
                     cv_ff       <= shs_pkg::INIT_HASH;
                     len_ff      <= '0;
                     end_pend_ff <= 1'b0;
                     pad_act_ff  <= 1'b0;
                     state_ff    <= ST_IDLE;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // channel outputs
   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = (state_ff == ST_OUT);
   assign rsp.digest_word = cv_ff[word_ff];
   assign rsp.word_number = word_ff;
   assign rsp.last_word   = (word_ff == shs_pkg::LAST_WORD_NUM);

`ifndef SYNTHESIS
   // no new message byte while a digest is being returned
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("req ready while digest words pending");

   // the 64th byte of a block starts a compression
   a_full_block_compresses: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.byte_present && (len_ff[5:0] == shs_pkg::BLOCK_LAST_POS))
      |=> (state_ff == ST_ROUND && rnd_ff == '0))
      else $error("full block did not start compression");

   // the last round hands over to the chaining update
   a_round_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == shs_pkg::LAST_ROUND) |=> (state_ff == ST_UPDATE))
      else $error("compression did not end after 64 rounds");

   // after the final word the hasher is back at its initial state
   a_restart_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp.last_word)
      |=> (req.ready && len_ff == '0 && cv_ff == shs_pkg::INIT_HASH))
      else $error("hasher not restarted after digest");

   // padding stays aligned: leaving a pad block only at its last byte
   a_pad_block_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && pos_ff != shs_pkg::BLOCK_LAST_POS) |=> (state_ff == ST_PAD))
      else $error("padding left block before its last byte");
`endif

endmodule

// ===== rtl/shs_round.sv =====
// ----------------------------------------------------------------------------
// shs_round
// One SHA-256 round plus one message schedule expansion step. The sequencer
// in the top level applies it once per cycle over the 64 rounds.
// ----------------------------------------------------------------------------
module shs_round (
   input  shs_pkg::shs_work_type  work,
   input  logic [511:0]           window,
   input  logic [31:0]            round_k,
   output shs_pkg::shs_work_type  work_next,
   output logic [31:0]            w_new
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // window word k holds W[t+k]; word 0 sits in the top bits
   logic [31:0] w0, w1, w9, w14;
   logic [31:0] sig0, sig1, big0, big1, ch, maj, t1, t2;

   assign w0  = window[511:480];
   assign w1  = window[479:448];
   assign w9  = window[223:192];
   assign w14 = window[63:32];

   // schedule: W[t+16] = s1(W[t+14]) + W[t+9] + s0(W[t+1]) + W[t]
   assign sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
   assign sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
   assign w_new = sig1 + w9 + sig0 + w0;

   // round function
   assign big1 = rotr(work.e, 6) ^ rotr(work.e, 11) ^ rotr(work.e, 25);
   assign ch   = (work.e & work.f) ^ (~work.e & work.g);
   assign t1   = work.h + big1 + ch + round_k + w0;
   assign big0 = rotr(work.a, 2) ^ rotr(work.a, 13) ^ rotr(work.a, 22);
   assign maj  = (work.a & work.b) ^ (work.a & work.c) ^ (work.b & work.c);
   assign t2   = big0 + maj;

   always_comb begin
      work_next   = work;
      work_next.h = work.g;
      work_next.g = work.f;
      work_next.f = work.e;
      work_next.e = work.d + t1;
      work_next.d = work.c;
      work_next.c = work.b;
      work_next.b = work.a;
      work_next.a = t1 + t2;
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the SHA-256 stream hasher. Messages go in one byte per
// transaction with random gaps; digest words come back under random stalls
// and are checked word by word against a digest predictor kept in a small
// scoreboard class.
// ----------------------------------------------------------------------------

// One expected digest word
typedef struct packed {
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;
} digest_entry_type;

// Digest predictor and store of pending digest words
class digest_scoreboard;
   logic [31:0]      chain [8];
   logic [0:63][7:0] block_bytes;
   logic [60:0]      byte_count;
   digest_entry_type pending_words [$];
   int unsigned      mismatches;

   function new();
      mismatches = 0;
      restart();
   endfunction

   // Back to the initial hash words and an empty message
   function void restart();
      int i;
      for (i = 0; i < 8; i++) begin
         chain[i] = shs_pkg::INIT_HASH[i];
      end
      block_bytes = '0;
      byte_count  = '0;
   endfunction

   static function logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // 64 rounds over one block, then the chaining update
   function void compress_block(input logic [0:63][7:0] blk);
      logic [0:15][31:0] w;
      logic [31:0]       r [8];
      logic [31:0]       a15, a2, s0, s1, t1, t2;
      int                t, i;
      w = blk;
      for (i = 0; i < 8; i++) begin
         r[i] = chain[i];
      end
      for (t = 0; t < 64; t++) begin
         // schedule word t replaces word t-16 in the window
         if (t >= 16) begin
            a15 = w[(t - 15) & 15];
            a2  = w[(t - 2) & 15];
            s0  = ror32(a15, 7) ^ ror32(a15, 18) ^ (a15 >> 3);
            s1  = ror32(a2, 17) ^ ror32(a2, 19) ^ (a2 >> 10);
            w[t & 15] = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
         end
         t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
            + ((r[4] & r[5]) ^ (~r[4] & r[6])) + shs_pkg::ROUND_K[t] + w[t & 15];
         t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
            + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6];
         r[6] = r[5];
         r[5] = r[4];
         r[4] = r[3] + t1;
         r[3] = r[2];
         r[2] = r[1];
         r[1] = r[0];
         r[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) begin
         chain[i] = chain[i] + r[i];
      end
   endfunction

   // Accepted request transaction: buffer the byte, finish on end of message
   function void note_request(input logic [7:0] data_byte, input logic byte_present,
                              input logic end_of_message);
      logic [0:127][7:0] tail;
      logic [63:0]       bit_count;
      digest_entry_type  entry;
      int                fill, pad_len, k;
      if (byte_present) begin
         block_bytes[byte_count[5:0]] = data_byte;
         byte_count = byte_count + 61'd1;
         if (byte_count[5:0] == 6'd0) begin
            compress_block(block_bytes);
         end
      end
      if (!end_of_message) begin
         return;
      end
      // padding: marker, zeros, big-endian bit count; spills when fill >= 56
      fill = byte_count[5:0];
      tail = '0;
      for (k = 0; k < fill; k++) begin
         tail[k] = block_bytes[k];
      end
      tail[fill] = shs_pkg::PAD_MARKER;
      pad_len = (fill < shs_pkg::LEN_FIELD_POS) ? 64 : 128;
      bit_count = {byte_count, 3'b000};
      for (k = 0; k < 8; k++) begin
         tail[pad_len - 1 - k] = bit_count[8 * k +: 8];
      end
      compress_block(tail[0:63]);
      if (pad_len == 128) begin
         compress_block(tail[64:127]);
      end
      for (k = 0; k < 8; k++) begin
         entry.digest_word = chain[k];
         entry.word_number = k[2:0];
         entry.last_word   = (k[2:0] == shs_pkg::LAST_WORD_NUM);
         pending_words.push_back(entry);
      end
      restart();
   endfunction

   // Accepted response transaction against the oldest pending word
   function void check_word(input logic [31:0] digest_word, input logic [2:0] word_number,
                            input logic last_word);
      digest_entry_type entry;
      if (pending_words.size() == 0) begin
         $error("digest word %h arrived with no digest pending", digest_word);
         mismatches++;
         return;
      end
      entry = pending_words.pop_front();
      if (digest_word !== entry.digest_word) begin
         $error("digest_word: expected %h, actual %h", entry.digest_word, digest_word);
         mismatches++;
      end
      if (word_number !== entry.word_number) begin
         $error("word_number: expected %0d, actual %0d", entry.word_number, word_number);
         mismatches++;
      end
      if (last_word !== entry.last_word) begin
         $error("last_word: expected %0d, actual %0d", entry.last_word, last_word);
         mismatches++;
      end
   endfunction
endclass

module tb;
   logic clock = 1'b0;
   logic reset = 1'b1;

   shs_req_if req_bus ();
   shs_rsp_if rsp_bus ();

   digest_scoreboard scbd;
   int               req_calm = 0;
   int               rsp_calm = 0;
   int               counted_items = 0;
   int               msg_len;

   sha256_stream_hasher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle cycles before the next transaction; now and then a run with none
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // One request transaction, held until accepted
   task automatic send_item(input logic [7:0] data_byte, input logic byte_present,
                            input logic end_of_message);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data_byte;
      req_bus.byte_present   <= byte_present;
      req_bus.end_of_message <= end_of_message;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      scbd.note_request(data_byte, byte_present, end_of_message);
      counted_items++;
   endtask

   // Random message of len bytes with some ignored transactions mixed in;
   // the end mark rides on the last byte or comes on its own
   task automatic send_message(input int len, input bit end_with_byte);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b0);
         end
         send_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
      end
      if (!end_with_byte || len == 0) begin
         send_item(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   // Request side and end of run
   initial begin
      scbd = new();
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= 8'h00;
      req_bus.byte_present   <= 1'b0;
      req_bus.end_of_message <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty message
      send_item(8'h00, 1'b0, 1'b1);
      // one byte together with the end mark
      send_item(8'hff, 1'b1, 1'b1);
      // end on its own; data bits ignored without byte_present
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      // ignored transaction, then "abc"
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);

      // padding fits in one block, then spills into a second one
      send_message(55, $urandom_range(0, 1));
      send_message(56, $urandom_range(0, 1));

      // mostly short messages, some around a block boundary
      while (counted_items < 160) begin
         msg_len = ($urandom_range(0, 4) == 0) ? 62 + $urandom_range(0, 4)
                                               : $urandom_range(0, 12);
         if (msg_len > 160 - counted_items) begin
            msg_len = 160 - counted_items;
         end
         send_message(msg_len, $urandom_range(0, 1));
      end
      req_bus.valid <= 1'b0;

      // drain, then a quiet stretch to catch stray words
      while (scbd.pending_words.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (scbd.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Response side: random stall before each word, then check it
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 || rsp_bus.ready !== 1'b1);
         scbd.check_word(rsp_bus.digest_word, rsp_bus.word_number, rsp_bus.last_word);
      end
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/shs_pkg.sv
rtl/shs_stream_if.sv
rtl/shs_round.sv
rtl/sha256_stream_hasher.sv
test/tb.sv
